// ===== rtl/psme_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// psme_pkg: shared types and constants
// Opcodes, error codes and controller/datapath command and status structs.
// ----------------------------------------------------------------------------
package psme_pkg;

	localparam logic [4:0] OP_LDA  = 5'd0;
	localparam logic [4:0] OP_LDC  = 5'd1;
	localparam logic [4:0] OP_LDV  = 5'd2;
	localparam logic [4:0] OP_JMP  = 5'd3;
	localparam logic [4:0] OP_JIF  = 5'd4;
	localparam logic [4:0] OP_ADD  = 5'd5;
	localparam logic [4:0] OP_SUB  = 5'd6;
	localparam logic [4:0] OP_MUL  = 5'd7;
	localparam logic [4:0] OP_DIV  = 5'd8;
	localparam logic [4:0] OP_INFE = 5'd9;
	localparam logic [4:0] OP_INF  = 5'd10;
	localparam logic [4:0] OP_SUP  = 5'd11;
	localparam logic [4:0] OP_SUPE = 5'd12;
	localparam logic [4:0] OP_EG   = 5'd13;
	localparam logic [4:0] OP_NEG  = 5'd14;
	localparam logic [4:0] OP_NOT  = 5'd15;
	localparam logic [4:0] OP_OR   = 5'd16;
	localparam logic [4:0] OP_AND  = 5'd17;
	localparam logic [4:0] OP_RD   = 5'd18;
	localparam logic [4:0] OP_WR   = 5'd19;
	localparam logic [4:0] OP_AFF  = 5'd20;

	localparam logic [1:0] ERR_NONE  = 2'd0;
	localparam logic [1:0] ERR_DIV0  = 2'd1;
	localparam logic [1:0] ERR_RANGE = 2'd2;
	localparam logic [1:0] ERR_OP    = 2'd3;

	localparam logic CFG_LAST_VAR = 1'b0;
	localparam logic CFG_PROG_LAST = 1'b1;

	// controller -> datapath
	typedef struct packed {
		logic start;     // load item, latch operands
		logic rd_a;      // read word at sp
		logic rd_b;      // read word at sp-1
		logic rd_c;      // read word at operand / address
		logic exec;      // start arithmetic
		logic commit;    // write memory, update sp/pc, load result
	} psme_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic alu_busy;
	} psme_sts_t;

endpackage
`default_nettype wire

// ===== rtl/psme_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// psme_div: signed divider
// Radix-2 restoring divider, one quotient bit per cycle, truncating to zero.
// ----------------------------------------------------------------------------
module psme_div
	import psme_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        go,
	input  wire logic [31:0] dividend,
	input  wire logic [31:0] divisor,
	output logic             busy,
	output logic [31:0]      quotient
);
	logic [31:0] rem_q, quo_q, den_q;
	logic [5:0]  cnt_q;
	logic        neg_q;
	logic [32:0] trial;
	logic [31:0] rem_sh;

	assign rem_sh = {rem_q[30:0], quo_q[31]};
	assign trial  = {1'b0, rem_sh} - {1'b0, den_q};
	assign busy   = (cnt_q != 6'd0);
	assign quotient = neg_q ? (32'd0 - quo_q) : quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 6'd0;
		end else if (go) begin
			cnt_q <= 6'd32;
		end else if (busy) begin
			cnt_q <= cnt_q - 6'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			rem_q <= 32'd0;
			quo_q <= dividend[31] ? (32'd0 - dividend) : dividend;
			den_q <= divisor[31] ? (32'd0 - divisor) : divisor;
			neg_q <= dividend[31] ^ divisor[31];
		end else if (busy) begin
			if (!trial[32]) begin
				rem_q <= trial[31:0];
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end
endmodule
`default_nettype wire

// ===== rtl/psme_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// psme_datapath: data memory, stack pointer, counter and ALU
// Reads operands from the data memory, combines them, and commits results.
// ----------------------------------------------------------------------------
module psme_datapath
	import psme_pkg::*;
#(
	parameter int MEM_DEPTH = 256,
	parameter int PC_WIDTH  = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire psme_cmd_t   cmd,
	output psme_sts_t        sts,
	input  wire logic        action,
	input  wire logic [4:0]  opcode,
	input  wire logic [31:0] operand,
	input  wire logic [31:0] read_value,
	input  wire logic [8:0]  last_var_q,
	input  wire logic [15:0] prog_last_q,
	input  wire logic        clr_busy,
	output logic             clr_done,
	output logic [15:0]      next_pc,
	output logic             write_valid,
	output logic [31:0]      write_value,
	output logic             done_res,
	output logic [1:0]       error
);
	localparam int AW = $clog2(MEM_DEPTH);
	localparam int SW = (AW + 2 > 9) ? AW + 2 : 9;

	logic [31:0] mem [MEM_DEPTH];
	logic [AW-1:0] clr_idx_q;

	logic              act_s1;
	logic [4:0]        op_s1;
	logic [31:0]       opnd_s1, rdv_s1;
	logic signed [SW-1:0] sp_q;
	logic [PC_WIDTH-1:0]  pc_q;
	logic [31:0] top_q, below_q, cval_q, alu_q, mul_q;
	logic        div0_q;

	logic signed [SW-1:0] sp_p1, sp_m1, lv_ext;
	logic ok_sp, ok_p1, ok_m1, ok_opnd, ok_below;
	logic [AW-1:0] raddr;
	logic [31:0] rdata;
	logic        div_go, div_busy;
	logic [31:0] quo;

	function automatic logic in_rng(input logic [31:0] v);
		in_rng = (v[31] == 1'b0) && ({1'b0, v} < 33'(MEM_DEPTH));
	endfunction

	assign lv_ext = SW'(signed'(last_var_q));
	assign sp_p1 = sp_q + SW'(1);
	assign sp_m1 = sp_q - SW'(1);
	assign ok_sp = in_rng(32'(sp_q));
	assign ok_p1 = in_rng(32'(sp_p1));
	assign ok_m1 = in_rng(32'(sp_m1));
	assign ok_opnd  = in_rng(opnd_s1);
	assign ok_below = in_rng(below_q);

	always_comb begin
		raddr = sp_q[AW-1:0];
		if (cmd.rd_b) raddr = sp_m1[AW-1:0];
		if (cmd.rd_c) raddr = (op_s1 == OP_LDV) ? opnd_s1[AW-1:0] : below_q[AW-1:0];
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

	assign clr_done = (clr_idx_q == AW'(MEM_DEPTH - 1));
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) clr_idx_q <= '0;
		else if (clr_busy && !clr_done) clr_idx_q <= clr_idx_q + AW'(1);
	end

	assign div_go = cmd.exec && (op_s1 == OP_DIV) && (top_q != 32'd0);
	psme_div u_div (
		.clk(clk), .arst_n(arst_n), .go(div_go), .dividend(below_q),
		.divisor(top_q), .busy(div_busy), .quotient(quo)
	);
	assign sts.alu_busy = div_busy;

	// read pipeline: rd_a -> top, rd_b -> below, rd_c -> cval (enables registered)
	logic rd_a_d, rd_b_d, rd_c_d;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_a_d <= 1'b0; rd_b_d <= 1'b0; rd_c_d <= 1'b0;
		end else begin
			rd_a_d <= cmd.rd_a; rd_b_d <= cmd.rd_b; rd_c_d <= cmd.rd_c;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			act_s1 <= action; op_s1 <= opcode; opnd_s1 <= operand; rdv_s1 <= read_value;
		end
		if (rd_a_d) top_q <= rdata;
		if (rd_b_d) below_q <= rdata;
		if (rd_c_d) cval_q <= rdata;
		if (cmd.exec) begin
			mul_q  <= below_q * top_q;
			div0_q <= (top_q == 32'd0);
		end
	end

	always_comb begin
		case (op_s1)
			OP_ADD:  alu_q = below_q + top_q;
			OP_SUB:  alu_q = below_q - top_q;
			OP_MUL:  alu_q = mul_q;
			OP_DIV:  alu_q = div0_q ? 32'd0 : quo;
			OP_INFE: alu_q = {31'd0, $signed(below_q) <= $signed(top_q)};
			OP_INF:  alu_q = {31'd0, $signed(below_q) <  $signed(top_q)};
			OP_SUP:  alu_q = {31'd0, $signed(below_q) >  $signed(top_q)};
			OP_SUPE: alu_q = {31'd0, $signed(below_q) >= $signed(top_q)};
			OP_EG:   alu_q = {31'd0, below_q == top_q};
			OP_NEG:  alu_q = {31'd0, below_q != top_q};
			OP_OR:   alu_q = {31'd0, (below_q != 0) || (top_q != 0)};
			default: alu_q = {31'd0, (below_q != 0) && (top_q != 0)};
		endcase
	end

	logic          we;
	logic [AW-1:0] waddr;
	logic [31:0]   wdata;
	logic signed [SW-1:0] sp_n;
	logic [PC_WIDTH-1:0]  pc_n;
	logic [1:0] err_n;
	logic       wv_n;

	always_comb begin
		we = 1'b0; waddr = sp_q[AW-1:0]; wdata = 32'd0;
		sp_n = sp_q; err_n = ERR_NONE; wv_n = 1'b0;
		pc_n = pc_q + PC_WIDTH'(1);
		if (!act_s1) begin
			sp_n = lv_ext; pc_n = '0;
		end else begin
			unique case (op_s1)
				OP_LDA, OP_LDC, OP_LDV, OP_RD: begin
					if (op_s1 != OP_RD) pc_n = pc_q + PC_WIDTH'(2);
					if (!ok_p1 || (op_s1 == OP_LDV && !ok_opnd)) begin
						err_n = ERR_RANGE;
					end else begin
						we = 1'b1; waddr = sp_p1[AW-1:0]; sp_n = sp_p1;
						wdata = (op_s1 == OP_LDV) ? cval_q :
							(op_s1 == OP_RD) ? rdv_s1 : opnd_s1;
					end
				end
				OP_JMP: pc_n = opnd_s1[PC_WIDTH-1:0];
				OP_JIF: begin
					pc_n = pc_q + PC_WIDTH'(2);
					if (!ok_sp) err_n = ERR_RANGE;
					else if (top_q == 32'd0) pc_n = opnd_s1[PC_WIDTH-1:0];
				end
				OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_INFE, OP_INF, OP_SUP, OP_SUPE,
				OP_EG, OP_NEG, OP_OR, OP_AND: begin
					if (!ok_sp || !ok_m1) begin
						err_n = ERR_RANGE;
					end else begin
						we = 1'b1; waddr = sp_m1[AW-1:0]; wdata = alu_q; sp_n = sp_m1;
						if (op_s1 == OP_DIV && div0_q) err_n = ERR_DIV0;
					end
				end
				OP_NOT: begin
					if (!ok_sp) err_n = ERR_RANGE;
					else begin
						we = 1'b1; wdata = {31'd0, top_q == 32'd0};
					end
				end
				OP_WR: begin
					if (!ok_sp) err_n = ERR_RANGE;
					else wv_n = 1'b1;
				end
				OP_AFF: begin
					if (!ok_sp || !ok_m1 || !ok_below) err_n = ERR_RANGE;
					else begin
						we = 1'b1; waddr = below_q[AW-1:0]; wdata = top_q;
						sp_n = sp_q - SW'(2);
					end
				end
				default: err_n = ERR_OP;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (clr_busy) mem[clr_idx_q] <= 32'd0;
		else if (cmd.commit && we) mem[waddr] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q <= '1;
			pc_q <= '0;
		end else if (cmd.commit) begin
			sp_q <= sp_n;
			pc_q <= pc_n;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			next_pc     <= 16'(pc_n);
			write_valid <= wv_n;
			write_value <= wv_n ? top_q : 32'd0;
			done_res    <= (32'(pc_n) > 32'(prog_last_q));
			error       <= err_n;
		end
	end
endmodule
`default_nettype wire

// ===== rtl/psme_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// psme_ctrl: instruction sequencer
// Steps each item through read, execute and commit, and runs the clear pass.
// ----------------------------------------------------------------------------
module psme_ctrl
	import psme_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_stall,
	input  wire logic      out_stall,
	output logic           out_valid,
	input  wire logic      clr_done,
	output logic           clr_busy,
	input  wire psme_sts_t sts,
	output psme_cmd_t      cmd
);
	localparam logic [2:0] S_CLR = 3'd0;
	localparam logic [2:0] S_IDLE = 3'd1;
	localparam logic [2:0] S_RA  = 3'd2;
	localparam logic [2:0] S_RB  = 3'd3;
	localparam logic [2:0] S_RC  = 3'd4;
	localparam logic [2:0] S_EX  = 3'd5;
	localparam logic [2:0] S_WT  = 3'd6;
	localparam logic [2:0] S_CM  = 3'd7;

	logic [2:0] state_q, state_n;
	logic       ov_q;
	logic       take;

	assign clr_busy  = (state_q == S_CLR);
	assign out_valid = ov_q;
	assign in_stall  = (state_q != S_IDLE) || (ov_q && out_stall);
	assign take      = in_valid && !in_stall;

	always_comb begin
		cmd = '0;
		state_n = state_q;
		unique case (state_q)
			S_CLR:  if (clr_done) state_n = S_IDLE;
			S_IDLE: if (take) begin cmd.start = 1'b1; state_n = S_RA; end
			S_RA:   begin cmd.rd_a = 1'b1; state_n = S_RB; end
			S_RB:   begin cmd.rd_b = 1'b1; state_n = S_RC; end
			S_RC:   begin cmd.rd_c = 1'b1; state_n = S_EX; end
			S_EX:   begin cmd.exec = 1'b1; state_n = S_WT; end
			S_WT:   if (!sts.alu_busy) state_n = S_CM;
			S_CM:   if (!(ov_q && out_stall)) begin cmd.commit = 1'b1; state_n = S_IDLE; end
			default: state_n = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_n;
			if (cmd.commit) ov_q <= 1'b1;
			else if (!out_stall) ov_q <= 1'b0;
		end
	end
endmodule
`default_nettype wire

// ===== rtl/pcode_stack_machine_execute.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcode_stack_machine_execute: p-code instruction executor
// Top level joining the sequencer, datapath and configuration registers.
// ----------------------------------------------------------------------------
// One item at a time. After reset the data memory is cleared, one word a cycle,
// before the first item is taken. The result is registered at commit, after
// three serial reads of the single-port data memory, execute and one wait step,
// and the next item is taken after commit at the earliest; DIV with a nonzero
// divisor stays in the wait step while the bit-serial divider runs.
// A stalled result holds off both commit and the next item.
module pcode_stack_machine_execute
	import psme_pkg::*;
#(
	parameter int MEM_DEPTH = 256,
	parameter int PC_WIDTH  = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        action,
	input  wire logic [4:0]  opcode,
	input  wire logic [31:0] operand,
	input  wire logic [31:0] read_value,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [15:0]      next_pc,
	output logic             write_valid,
	output logic [31:0]      write_value,
	output logic             done_res,
	output logic [1:0]       error,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        cfg_index,
	input  wire logic [31:0] cfg_data
);
	psme_cmd_t cmd;
	psme_sts_t sts;
	logic clr_busy, clr_done;
	logic [8:0]  last_var_q;
	logic [15:0] prog_last_q;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_var_q  <= '1;
			prog_last_q <= '0;
		end else if (cfg_valid) begin
			if (cfg_index == CFG_LAST_VAR) last_var_q <= cfg_data[8:0];
			else prog_last_q <= cfg_data[15:0];
		end
	end

	psme_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.out_stall(out_stall), .out_valid(out_valid), .clr_done(clr_done),
		.clr_busy(clr_busy), .sts(sts), .cmd(cmd)
	);

	psme_datapath #(.MEM_DEPTH(MEM_DEPTH), .PC_WIDTH(PC_WIDTH)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts), .action(action),
		.opcode(opcode), .operand(operand), .read_value(read_value),
		.last_var_q(last_var_q), .prog_last_q(prog_last_q), .clr_busy(clr_busy),
		.clr_done(clr_done), .next_pc(next_pc), .write_valid(write_valid),
		.write_value(write_value), .done_res(done_res), .error(error)
	);
endmodule
`default_nettype wire

// ===== rtl/psme_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// psme_port_checks: port-level checks
// Handshake and result consistency checks bound to the top level.
// ----------------------------------------------------------------------------
module psme_port_checks (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_stall,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic        write_valid,
	input wire logic [31:0] write_value,
	input wire logic [1:0]  error
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");
	a_wr_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !write_valid |-> write_value == 32'd0)
		else $error("write value without strobe");
	a_wr_noerr: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && write_valid |-> error == 2'd0)
		else $error("write with error");
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second item taken during execution");
endmodule

bind pcode_stack_machine_execute psme_port_checks u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .write_valid(write_valid),
	.write_value(write_value), .error(error)
);
`default_nettype wire

// ===== bench/psme_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psme_checker: result predictor and scoreboard
// Watches the input, output and register channels of the p-code executor,
// predicts each result from its own model of memory, stack and counter, and
// compares every result field against the oldest prediction.
// ----------------------------------------------------------------------------
module psme_checker
	import psme_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic        action,
	input  logic [4:0]  opcode,
	input  logic [31:0] operand,
	input  logic [31:0] read_value,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [15:0] next_pc,
	input  logic        write_valid,
	input  logic [31:0] write_value,
	input  logic        done_res,
	input  logic [1:0]  error,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data,
	output int          fail_count,
	output int          pending
);
	typedef struct packed {
		logic [15:0] pc;
		logic        wv;
		logic [31:0] wval;
		logic        done;
		logic [1:0]  err;
	} exec_result_t;

	logic [31:0]        mem [256];
	int                 sp;
	logic [15:0]        pc;
	logic signed [8:0]  last_var;
	logic [15:0]        prog_last;
	exec_result_t       pending_results [$];

	assign pending = pending_results.size();

	function automatic bit slot_ok(int i);
		return i >= 0 && i < 256;
	endfunction

	function automatic logic [31:0] alu(logic [4:0] op, logic [31:0] ua, logic [31:0] ub,
			inout logic [1:0] err);
		logic signed [31:0] a, b;
		a = ua;
		b = ub;
		case (op)
			OP_ADD:  return ua + ub;
			OP_SUB:  return ua - ub;
			OP_MUL:  return ua * ub;
			OP_DIV: begin
				if (b == 0) begin
					err = ERR_DIV0;
					return 0;
				end
				if (a == 32'sh80000000 && b == -1) return ua;
				return a / b;
			end
			OP_INFE: return {31'b0, a <= b};
			OP_INF:  return {31'b0, a < b};
			OP_SUP:  return {31'b0, a > b};
			OP_SUPE: return {31'b0, a >= b};
			OP_EG:   return {31'b0, a == b};
			OP_NEG:  return {31'b0, a != b};
			OP_OR:   return {31'b0, (ua != 0) || (ub != 0)};
			default: return {31'b0, (ua != 0) && (ub != 0)};
		endcase
	endfunction

	task automatic execute_item(logic act, logic [4:0] op, logic [31:0] opd,
			logic [31:0] rdv);
		exec_result_t r;
		logic [15:0]  step;
		bit           jump;
		int           addr;
		step = 1;
		jump = 0;
		r = '0;
		r.err = ERR_NONE;
		if (!act) begin
			sp = last_var;
			pc = 0;
		end else begin
			case (op)
				OP_LDA, OP_LDC, OP_LDV: begin
					step = 2;
					if (!slot_ok(sp + 1)) r.err = ERR_RANGE;
					else if (op == OP_LDV) begin
						addr = $signed(opd);
						if (!slot_ok(addr)) r.err = ERR_RANGE;
						else begin
							mem[sp + 1] = mem[addr];
							sp++;
						end
					end else begin
						mem[sp + 1] = opd;
						sp++;
					end
				end
				OP_JMP: jump = 1;
				OP_JIF: begin
					step = 2;
					if (!slot_ok(sp)) r.err = ERR_RANGE;
					else if (mem[sp] == 0) jump = 1;
				end
				OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_INFE, OP_INF, OP_SUP, OP_SUPE,
				OP_EG, OP_NEG, OP_OR, OP_AND: begin
					if (!slot_ok(sp) || !slot_ok(sp - 1)) r.err = ERR_RANGE;
					else begin
						mem[sp - 1] = alu(op, mem[sp - 1], mem[sp], r.err);
						sp--;
					end
				end
				OP_NOT: begin
					if (!slot_ok(sp)) r.err = ERR_RANGE;
					else mem[sp] = (mem[sp] == 0) ? 32'd1 : 32'd0;
				end
				OP_RD: begin
					if (!slot_ok(sp + 1)) r.err = ERR_RANGE;
					else begin
						mem[sp + 1] = rdv;
						sp++;
					end
				end
				OP_WR: begin
					if (!slot_ok(sp)) r.err = ERR_RANGE;
					else begin
						r.wv = 1;
						r.wval = mem[sp];
					end
				end
				OP_AFF: begin
					if (!slot_ok(sp) || !slot_ok(sp - 1)) r.err = ERR_RANGE;
					else begin
						addr = $signed(mem[sp - 1]);
						if (!slot_ok(addr)) r.err = ERR_RANGE;
						else begin
							mem[addr] = mem[sp];
							sp -= 2;
						end
					end
				end
				default: r.err = ERR_OP;
			endcase
			pc = jump ? opd[15:0] : pc + step;
		end
		r.pc = pc;
		r.done = pc > prog_last;
		pending_results.push_back(r);
	endtask

	always @(posedge clk or negedge arst_n) begin
		exec_result_t e;
		if (!arst_n) begin
			foreach (mem[i]) mem[i] = '0;
			sp = -1;
			pc = 0;
			last_var = -1;
			prog_last = 0;
			fail_count = 0;
			pending_results.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_LAST_VAR) last_var = cfg_data[8:0];
				else prog_last = cfg_data[15:0];
			end
			if (out_valid && !out_stall) begin
				if (pending_results.size() == 0) begin
					$error("result with no prediction waiting");
					fail_count++;
				end else begin
					e = pending_results.pop_front();
					if (next_pc !== e.pc) begin
						$error("next_pc exp %h got %h", e.pc, next_pc);
						fail_count++;
					end
					if (write_valid !== e.wv) begin
						$error("write_valid exp %b got %b", e.wv, write_valid);
						fail_count++;
					end
					if (write_value !== e.wval) begin
						$error("write_value exp %h got %h", e.wval, write_value);
						fail_count++;
					end
					if (done_res !== e.done) begin
						$error("done_res exp %b got %b", e.done, done_res);
						fail_count++;
					end
					if (error !== e.err) begin
						$error("error exp %0d got %0d", e.err, error);
						fail_count++;
					end
				end
			end
			if (in_valid && !in_stall) execute_item(action, opcode, operand, read_value);
		end
	end
endmodule

// ===== bench/tb_pcode_stack_machine_execute.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pcode_stack_machine_execute: executor regression
// Drives directed and random instruction streams, invalid opcodes among them,
// through several register settings and idling and stalling phases; the checker predicts
// and compares every result.
// ----------------------------------------------------------------------------
module tb_pcode_stack_machine_execute;
	import psme_pkg::*;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        in_valid = 0;
	logic        in_stall;
	logic        action = 0;
	logic [4:0]  opcode = 0;
	logic [31:0] operand = 0;
	logic [31:0] read_value = 0;
	logic        out_valid;
	logic        out_stall = 0;
	logic [15:0] next_pc;
	logic        write_valid;
	logic [31:0] write_value;
	logic        done_res;
	logic [1:0]  error;
	logic        cfg_valid = 0;
	logic        cfg_ready;
	logic        cfg_index = 0;
	logic [31:0] cfg_data = 0;
	int          fail_count;
	int          pending;
	int          send_idle_pct = 0;
	int          recv_stall_pct = 0;

	pcode_stack_machine_execute uut (.*);
	psme_checker chk (.*);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	always @(negedge clk) out_stall <= ($urandom_range(99) < recv_stall_pct);

	task automatic send_item(logic act, logic [4:0] op, logic [31:0] opd, logic [31:0] rdv);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 0;
			@(negedge clk);
		end
		in_valid <= 1;
		action <= act;
		opcode <= op;
		operand <= opd;
		read_value <= rdv;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 0;
		while (pending != 0) @(negedge clk);
		repeat (60) @(negedge clk);
	endtask

	task automatic write_reg(logic idx, logic [31:0] val);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 0;
		@(negedge clk);
	endtask

	function automatic logic [31:0] rand_word();
		case ($urandom_range(5))
			0: return 32'h80000000;
			1: return 32'h7fffffff;
			2: return 32'hffffffff;
			3: return 0;
			4: return $urandom_range(15);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [31:0] rand_addr();
		if ($urandom_range(9) == 0) return rand_word();
		return $urandom_range(20);
	endfunction

	task automatic random_item();
		logic [4:0] op;
		logic [31:0] opd;
		op = ($urandom_range(19) == 0) ? 5'($urandom_range(31, 21)) : 5'($urandom_range(20));
		if (op == OP_LDV) opd = rand_addr();
		else if (op == OP_JMP || op == OP_JIF) opd = $urandom;
		else opd = rand_word();
		if (op == OP_LDC && $urandom_range(2) == 0) opd = rand_addr();
		send_item($urandom_range(39) != 0, op, opd, rand_word());
	endtask

	task automatic random_program(int len);
		send_item(0, OP_LDA, $urandom, $urandom);
		repeat (len) random_item();
	endtask

	initial begin
		int phase;
		repeat (3) @(negedge clk);
		arst_n = 1;
		// directed: extremes and special cases with default registers
		send_item(1, OP_ADD, 0, 0);
		send_item(1, OP_WR, 0, 0);
		send_item(1, OP_JIF, 32'hffffffff, 0);
		send_item(1, 5'd31, 0, 0);
		send_item(1, OP_LDC, 32'h80000000, 0);
		send_item(1, OP_LDC, 32'hffffffff, 0);
		send_item(1, OP_DIV, 0, 0);
		send_item(1, OP_WR, 0, 0);
		send_item(1, OP_LDC, 0, 0);
		send_item(1, OP_DIV, 0, 0);
		send_item(1, OP_RD, 0, 32'h7fffffff);
		send_item(1, OP_LDV, 32'hffffffff, 0);
		send_item(1, OP_LDV, 256, 0);
		send_item(1, OP_LDV, 255, 0);
		send_item(1, OP_JIF, 32'h1234ffff, 0);
		send_item(1, OP_NOT, 0, 0);
		send_item(1, OP_AFF, 0, 0);
		send_item(1, OP_JMP, 32'hfffffffe, 0);
		send_item(0, OP_LDA, 0, 0);
		drain();
		write_reg(CFG_LAST_VAR, 32'h0ff);
		write_reg(CFG_PROG_LAST, 32'hffff);
		send_item(0, OP_LDA, 0, 0);
		send_item(1, OP_RD, 0, 5);
		send_item(1, OP_WR, 0, 0);
		send_item(1, OP_JIF, 3, 0);
		drain();
		for (phase = 0; phase < 8; phase++) begin
			case (phase % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 67; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 67; end
				default: begin send_idle_pct = 14; recv_stall_pct = 14; end
			endcase
			case (phase)
				0: write_reg(CFG_LAST_VAR, 32'h1ff);
				3: write_reg(CFG_LAST_VAR, 32'h0f0);
				7: write_reg(CFG_LAST_VAR, 32'h0fc);
				default: write_reg(CFG_LAST_VAR, $urandom_range(12));
			endcase
			write_reg(CFG_PROG_LAST, (phase == 2) ? 0 : $urandom_range(40));
			repeat (7) random_program($urandom_range(8, 14));
			drain();
		end
		send_idle_pct = 0;
		recv_stall_pct = 0;
		drain();
		if (fail_count == 0) $display("Regression PASS");
		else $display("Regression FAIL");
		$finish;
	end

	initial begin
		#20ms;
		$display("Regression FAIL");
		$finish;
	end
endmodule

// ===== filelist.f =====
rtl/psme_pkg.sv
rtl/psme_div.sv
rtl/psme_datapath.sv
rtl/psme_ctrl.sv
rtl/pcode_stack_machine_execute.sv
rtl/psme_checker.sv
bench/psme_checker.sv
bench/tb_pcode_stack_machine_execute.sv
